FILE: rtl/wrms_pkg.sv
// shared types and constants for the weighted running mean and deviation block
// no dependencies
package wrms_pkg;

  localparam int unsigned IterW = 7;

  localparam logic [IterW-1:0] DIV_MEAN_ITERS = 7'd49;
  localparam logic [IterW-1:0] DIV_VAR_ITERS  = 7'd80;
  localparam logic [IterW-1:0] SQRT_ITERS     = 7'd32;

  typedef struct packed {
    logic             go;
    logic             is_sqrt;
    logic [IterW-1:0] iters;
  } iter_cmd_t;

endpackage

FILE: rtl/wrms_if.sv
// request channels of the weighted running mean and deviation block
// no dependencies
interface wrms_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        weight;
  logic signed [31:0] sample;
  logic               start_req;
  modport source (output valid, weight, sample, start_req, input ready);
  modport sink (input valid, weight, sample, start_req, output ready);
endinterface

interface wrms_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mean;
  logic [31:0]        deviation;
  logic               no_weight;
  modport source (output valid, mean, deviation, no_weight, input ready);
  modport sink (input valid, mean, deviation, no_weight, output ready);
endinterface

FILE: rtl/weighted_running_mean_std_top.sv
// Weighted running mean and standard deviation (weighted Welford update), Q16.16 values,
// Q8.8 weights. A new request is taken only in the idle state, so each request is worked
// through before the next is taken; a zero total weight goes straight to the output. Two
// bit-serial divisions (49 and 80 steps) and a 32 step square root share one subtractor in
// wrms_iter, each with a go state and a wait state; the mean update, difference, two multiply,
// term and accumulate states lie between the first division and the second. A finished result
// sits in the output register while the next request is worked on.
// depends on wrms_pkg, wrms_if, wrms_iter
module weighted_running_mean_std_top (
  input  logic clk_i,
  input  logic rst_ni,
  wrms_in_if.sink    in_i,
  wrms_out_if.source out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV1_GO, S_DIV1_WAIT, S_MEAN, S_DIFF, S_MUL_LO, S_MUL_HI,
    S_TERM, S_ACC, S_DIV2_GO, S_DIV2_WAIT, S_SQRT_GO, S_SQRT_WAIT, S_DONE
  } state_e;

  state_e             state_q;
  logic [31:0]        ws_q;
  logic signed [31:0] mean_q;
  logic [63:0]        sds_q;
  logic [15:0]        w_q;
  logic signed [31:0] x_q;
  logic               neg_q;
  logic [47:0]        a_q;
  logic [31:0]        ad2_q;
  logic [63:0]        plo_q;
  logic [47:0]        phi_q;
  logic [63:0]        term_q;
  logic [31:0]        dev_q;
  logic               out_valid_q;
  logic signed [31:0] out_mean_q;
  logic [31:0]        out_dev_q;
  logic               out_nw_q;

  wrms_pkg::iter_cmd_t cmd;
  logic [79:0]         dividend;
  logic [63:0]         radicand;
  logic                iter_busy;
  logic [79:0]         quot;
  logic [31:0]         root;

  logic [32:0] ws_sum;
  logic [32:0] delta;
  logic [32:0] abs_delta;
  logic [48:0] num1;
  logic [32:0] nmean;
  logic [64:0] term_sum;
  logic [64:0] acc_sum;
  logic        accept;

  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    ws_sum    = {1'b0, in_i.start_req ? 32'b0 : ws_q} + {17'b0, in_i.weight};
    delta     = {x_q[31], x_q} - {mean_q[31], mean_q};
    abs_delta = delta[32] ? (33'b0 - delta) : delta;
    num1      = {1'b0, a_q} + {18'b0, ws_q[31:1]};
    nmean     = neg_q ? ({mean_q[31], mean_q} - {1'b0, quot[31:0]})
                      : ({mean_q[31], mean_q} + {1'b0, quot[31:0]});
    term_sum  = {1'b0, phi_q, 16'b0} + {17'b0, plo_q[63:16]};
    acc_sum   = {1'b0, sds_q} + {1'b0, term_q};
    radicand  = (quot[79:64] != 16'b0) ? {64{1'b1}} : quot[63:0];
    dividend  = (state_q == S_DIV1_GO) ? {num1, 31'b0} : {sds_q, 16'b0};
    cmd       = '0;
    unique case (state_q)
      S_DIV1_GO: begin
        cmd.go    = 1'b1;
        cmd.iters = wrms_pkg::DIV_MEAN_ITERS;
      end
      S_DIV2_GO: begin
        cmd.go    = 1'b1;
        cmd.iters = wrms_pkg::DIV_VAR_ITERS;
      end
      S_SQRT_GO: begin
        cmd.go      = 1'b1;
        cmd.is_sqrt = 1'b1;
        cmd.iters   = wrms_pkg::SQRT_ITERS;
      end
      default: cmd = '0;
    endcase
  end

  wrms_iter u_iter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .dividend_i (dividend),
    .divisor_i  (ws_q),
    .radicand_i (radicand),
    .busy_o     (iter_busy),
    .quot_o     (quot),
    .root_o     (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ws_q        <= '0;
      mean_q      <= '0;
      sds_q       <= '0;
      w_q         <= '0;
      x_q         <= '0;
      neg_q       <= 1'b0;
      a_q         <= '0;
      ad2_q       <= '0;
      plo_q       <= '0;
      phi_q       <= '0;
      term_q      <= '0;
      dev_q       <= '0;
      out_valid_q <= 1'b0;
      out_mean_q  <= '0;
      out_dev_q   <= '0;
      out_nw_q    <= 1'b0;
    end else begin
      if (out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            ws_q    <= ws_sum[32] ? 32'hFFFF_FFFF : ws_sum[31:0];
            w_q     <= in_i.weight;
            x_q     <= in_i.sample;
            if (in_i.start_req) begin
              mean_q <= '0;
              sds_q  <= '0;
            end
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          neg_q <= delta[32];
          a_q   <= {32'b0, w_q} * {16'b0, abs_delta[31:0]};
          dev_q <= '0;
          state_q <= (ws_q == 32'b0) ? S_DONE : S_DIV1_GO;
        end
        S_DIV1_GO:   state_q <= S_DIV1_WAIT;
        S_DIV1_WAIT: if (!iter_busy) state_q <= S_MEAN;
        S_MEAN: begin
          mean_q  <= nmean[31:0];
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          ad2_q   <= abs_delta[31:0];
          state_q <= S_MUL_LO;
        end
        S_MUL_LO: begin
          plo_q   <= {32'b0, a_q[31:0]} * {32'b0, ad2_q};
          state_q <= S_MUL_HI;
        end
        S_MUL_HI: begin
          phi_q   <= {32'b0, a_q[47:32]} * {16'b0, ad2_q};
          state_q <= S_TERM;
        end
        S_TERM: begin
          term_q  <= term_sum[64] ? {64{1'b1}} : term_sum[63:0];
          state_q <= S_ACC;
        end
        S_ACC: begin
          sds_q   <= acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];
          state_q <= S_DIV2_GO;
        end
        S_DIV2_GO:   state_q <= S_DIV2_WAIT;
        S_DIV2_WAIT: if (!iter_busy) state_q <= S_SQRT_GO;
        S_SQRT_GO:   state_q <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (!iter_busy) begin
            dev_q   <= root;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_mean_q  <= mean_q;
            out_dev_q   <= dev_q;
            out_nw_q    <= (ws_q == 32'b0);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.mean      = out_mean_q;
  assign out_o.deviation = out_dev_q;
  assign out_o.no_weight = out_nw_q;

endmodule

FILE: rtl/wrms_iter.sv
// shared iterative unit: restoring divider (80 bit dividend) and integer square root
// one bit per cycle over a single 65 bit subtractor; depends on wrms_pkg
module wrms_iter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wrms_pkg::iter_cmd_t cmd_i,
  input  logic [79:0]         dividend_i,
  input  logic [31:0]         divisor_i,
  input  logic [63:0]         radicand_i,
  output logic                busy_o,
  output logic [79:0]         quot_o,
  output logic [31:0]         root_o
);

  logic                     busy_q;
  logic                     sqrt_q;
  logic [wrms_pkg::IterW-1:0] cnt_q;
  logic [31:0]              div_q;
  logic [31:0]              rem_q;
  logic [79:0]              sh_q;
  logic [63:0]              res_q;
  logic [63:0]              bit_q;

  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [64:0] diff;
  logic        ge;

  always_comb begin
    if (sqrt_q) begin
      op_a = sh_q[63:0];
      op_b = res_q + bit_q;
    end else begin
      op_a = {31'b0, rem_q, sh_q[79]};
      op_b = {32'b0, div_q};
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = ~diff[64];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= '0;
      rem_q  <= '0;
      res_q  <= '0;
      bit_q  <= '0;
      sh_q   <= '0;
    end else if (cmd_i.go) begin
      busy_q <= 1'b1;
      sqrt_q <= cmd_i.is_sqrt;
      cnt_q  <= cmd_i.iters;
      div_q  <= divisor_i;
      rem_q  <= '0;
      res_q  <= '0;
      bit_q  <= 64'h4000_0000_0000_0000;
      sh_q   <= cmd_i.is_sqrt ? {16'b0, radicand_i} : dividend_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == wrms_pkg::IterW'(1)) begin
        busy_q <= 1'b0;
      end
      if (sqrt_q) begin
        if (ge) begin
          sh_q[63:0] <= diff[63:0];
          res_q      <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end else begin
        rem_q <= ge ? diff[31:0] : op_a[31:0];
        sh_q  <= {sh_q[78:0], ge};
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = sh_q;
  assign root_o = res_q[31:0];

endmodule

FILE: sim/weighted_running_mean_std_top_tb.sv
// testbench for the weighted running mean and deviation block: directed and random requests,
// each result checked against a built-in weighted welford predictor
// depends on wrms_if and weighted_running_mean_std_top
`timescale 1ns / 1ps

module weighted_running_mean_std_top_tb;

  typedef struct packed {
    logic signed [31:0] mean;
    logic [31:0]        deviation;
    logic               no_weight;
  } wrms_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned idle_pct = 37;
  logic [15:0] noise_weight;
  logic signed [31:0] noise_sample;

  wrms_in_if  in_if ();
  wrms_out_if out_if ();

  weighted_running_mean_std_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predictor state
  logic [31:0] acc_weight;
  logic signed [31:0] acc_mean;
  logic [63:0] acc_sqdev;
  wrms_result_t expected_q[$];

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("weighted_running_mean_std_top regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic logic [31:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] bitv;
    root = 0;
    rem = v;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  function automatic wrms_result_t predict_welford(input logic [15:0] w,
                                                   input logic signed [31:0] x,
                                                   input logic strt);
    wrms_result_t r;
    logic [32:0] wsum;
    logic signed [33:0] delta, d2, nmean;
    logic [33:0] ad, ad2;
    logic [63:0] prod, inc, s, plo, phi, term, q1, rem, q;
    if (strt) begin
      acc_weight = 0;
      acc_mean = 0;
      acc_sqdev = 0;
    end
    wsum = {1'b0, acc_weight} + {17'd0, w};
    acc_weight = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
    r.deviation = 0;
    if (acc_weight != 0) begin
      delta = 34'(x) - 34'(acc_mean);
      ad = delta < 0 ? -delta : delta;
      s = {32'd0, acc_weight};
      prod = {48'd0, w} * {30'd0, ad};
      inc = (prod + s / 2) / s;
      nmean = delta < 0 ? acc_mean - $signed({1'b0, inc[32:0]})
                        : acc_mean + $signed({1'b0, inc[32:0]});
      d2 = 34'(x) - nmean;
      ad2 = d2 < 0 ? -d2 : d2;
      plo = {32'd0, prod[31:0]} * {30'd0, ad2};
      phi = {32'd0, prod[63:32]} * {30'd0, ad2};
      term = sat_add(phi << 16, plo >> 16);
      acc_mean = nmean[31:0];
      acc_sqdev = sat_add(acc_sqdev, term);
      q1 = acc_sqdev / s;
      rem = acc_sqdev % s;
      q = (q1 >> 48) != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : sat_add(q1 << 16, (rem << 16) / s);
      r.deviation = int_sqrt(q);
    end
    r.mean = acc_mean;
    r.no_weight = acc_weight == 0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic send_request(input logic [15:0] w, input logic signed [31:0] x,
                              input logic strt);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      in_if.weight <= noise_weight;
      in_if.sample <= noise_sample;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.weight <= w;
    in_if.sample <= x;
    in_if.start_req <= strt;
    do @(posedge clk_i); while (!in_if.ready);
    expected_q.push_back(predict_welford(w, x, strt));
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= idle_pct);
    noise_weight <= 16'($urandom);
    noise_sample <= $urandom;
  end

  always @(posedge clk_i) begin
    wrms_result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_if.mean, 0);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_if.mean !== exp_r.mean) report_mismatch("mean", out_if.mean, exp_r.mean);
        if (out_if.deviation !== exp_r.deviation)
          report_mismatch("deviation", out_if.deviation, exp_r.deviation);
        if (out_if.no_weight !== exp_r.no_weight)
          report_mismatch("no_weight", {31'd0, out_if.no_weight}, {31'd0, exp_r.no_weight});
      end
    end
  end

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(512));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(65536 * 8)) - 32'sd262144;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    send_request(16'd0, 32'sd0, 1'b1);
    send_request(16'd0, 32'sh7FFF_FFFF, 1'b0);
    send_request(16'hFFFF, 32'sh7FFF_FFFF, 1'b0);
    send_request(16'hFFFF, 32'sh8000_0000, 1'b0);
    send_request(16'd0, 32'sd12345, 1'b0);
    send_request(16'd1, 32'sh8000_0000, 1'b1);
    send_request(16'hFFFF, 32'sh7FFF_FFFF, 1'b0);
    send_request(16'd256, 32'sh0001_0000, 1'b1);
    send_request(16'd256, 32'sh0003_0000, 1'b0);
    send_request(16'd1, 32'sd1, 1'b0);
  endtask

  task automatic test_weight_saturation();
    send_request(16'hFFFF, 32'sh7FFF_FFFF, 1'b1);
    repeat (12) send_request(16'hFFFF, 32'sh8000_0000, 1'b0);
    repeat (12) send_request(16'hFFFF, 32'sh7FFF_FFFF, 1'b0);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    in_if.weight <= noise_weight;
    in_if.sample <= noise_sample;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic test_random(input int unsigned n);
    repeat (n) send_request(rand_weight(), rand_sample(), $urandom_range(15) == 0);
  endtask

  task automatic test_random_no_idle(input int unsigned n);
    idle_pct = 0;
    test_random(n);
    idle_pct = 37;
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.weight = 16'd0;
    in_if.sample = 32'sd0;
    in_if.start_req = 1'b0;
    out_if.ready = 1'b0;
    acc_weight = 0;
    acc_mean = 0;
    acc_sqdev = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes();
    test_weight_saturation();
    drain();
    test_random(450);
    test_random_no_idle(150);
    test_random(300);
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("weighted_running_mean_std_top regression: pass");
    end else begin
      $display("weighted_running_mean_std_top regression: fail");
    end
    $finish;
  end

endmodule
